### hw/rtl/smallest_three_quaternion_unpacker_core_assert.svh
// assertion macros used by smallest_three_quaternion_unpacker_core
`ifndef SMALLEST_THREE_QUATERNION_UNPACKER_CORE_ASSERT_SVH
`define SMALLEST_THREE_QUATERNION_UNPACKER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SQTQ_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SQTQ_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SQTQ_ASSERT_IMP(label, clk, rst_n, a, c)
`define SQTQ_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/sqtq_pkg.sv
// ----------------------------------------------------------------------------
// sqtq_pkg
// shared constants and lane type of the smallest-three rotation decoder
// ----------------------------------------------------------------------------
package sqtq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int BYTE_W    = 8;
    localparam int OUT_W     = 16;
    localparam int LANES     = 4;
    localparam int N_W       = FRAC_BITS + 1;          // root value 0 .. 2^FRAC_BITS
    localparam int STAGES    = N_W;                    // one cell per result bit
    localparam int BIT_W     = $clog2(STAGES);
    localparam int T_W       = 17;                     // squared byte or remainder
    localparam int M_W       = 18;                     // squared length
    localparam int ACC_W     = 2 * N_W + M_W + 4;      // candidate product, signed

    localparam logic [BYTE_W-1:0] TAG_BASE = 8'd252;
    localparam logic [M_W-1:0]    UNIT_SQ  = 18'd130050;

    localparam logic [1:0] SLOT_W = 2'd0;
    localparam logic [1:0] SLOT_X = 2'd1;
    localparam logic [1:0] SLOT_Y = 2'd2;
    localparam logic [1:0] SLOT_Z = 2'd3;

    // one root being resolved, one bit per cell
    typedef struct packed {
        logic [N_W-1:0]          n;     // bits resolved so far
        logic signed [ACC_W-1:0] p;     // (2n-1)^2 * m
        logic signed [ACC_W-1:0] q;     // (2n-1) * m
        logic [M_W-1:0]          m;
        logic [T_W-1:0]          t;
        logic                    neg;
    } lane_t;

endpackage

### hw/rtl/sqtq_cell.sv
// ----------------------------------------------------------------------------
// sqtq_cell
// one step of the rounded root search: tries one result bit for one lane
// ----------------------------------------------------------------------------
module sqtq_cell
    import sqtq_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [BIT_W-1:0] bit_idx,
    input  lane_t            lane_in,
    output lane_t            lane_out
);

    logic signed [ACC_W-1:0] m_ext;
    logic signed [ACC_W-1:0] t_scaled;
    logic signed [ACC_W-1:0] cand_p;
    logic signed [ACC_W-1:0] cand_q;
    logic [N_W-1:0]          bit_mask;
    lane_t                   lane_next;

    // (2(n+b)-1)^2 m = p + 4b q + 4b^2 m, with b a power of two
    always_comb
    begin
        m_ext     = $signed({{(ACC_W-M_W){1'b0}}, lane_in.m});
        t_scaled  = $signed({{(ACC_W-T_W-2*FRAC_BITS-2){1'b0}}, lane_in.t,
                             {(2*FRAC_BITS+2){1'b0}}});
        bit_mask  = N_W'(1) << bit_idx;
        cand_p    = lane_in.p + (lane_in.q <<< ({1'b0, bit_idx} + (BIT_W+1)'(2)))
                    + (m_ext <<< ({1'b0, bit_idx} + {1'b0, bit_idx} + (BIT_W+1)'(2)));
        cand_q    = lane_in.q + (m_ext <<< ({1'b0, bit_idx} + (BIT_W+1)'(1)));
        lane_next = lane_in;
        if (cand_p <= t_scaled)
        begin
            lane_next.n = lane_in.n | bit_mask;
            lane_next.p = cand_p;
            lane_next.q = cand_q;
        end
    end

    // stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_out <= lane_next;
        end
    end

endmodule

### hw/rtl/smallest_three_quaternion_unpacker_core.sv
// ----------------------------------------------------------------------------
// smallest_three_quaternion_unpacker_core
// decodes a smallest-three packed rotation into a normalized fixed-point quaternion
// ----------------------------------------------------------------------------
// One rotation is taken per cycle; it passes through one front stage, then a
// row of 15 cells that each settle one bit of every rounded root. Throughput
// is one transfer per cycle while m_tready is high; a low m_tready while
// m_tvalid is high stalls the whole row. Outputs carry 14 fraction bits,
// rounded to nearest; a tag outside 252..255 decodes as w and sets tuser.
`include "smallest_three_quaternion_unpacker_core_assert.svh"
module smallest_three_quaternion_unpacker_core
    import sqtq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // packed_first, packed_second, packed_third, largest_tag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // rot_x, rot_y, rot_z, rot_w
    output logic        m_tuser    // tag_invalid
);

    logic                     advance;
    logic [STAGES:0]          vld_reg;
    logic [STAGES:0]          vld_next;
    logic [STAGES:0]          bad_reg;
    lane_t                    front_reg [LANES];
    lane_t                    front_next [LANES];
    lane_t                    chain [STAGES][LANES];

    logic [BYTE_W-1:0]        byte_in [3];
    logic [BYTE_W-1:0]        tag;
    logic [BYTE_W-1:0]        mag [3];
    logic                     neg [3];
    logic [T_W-1:0]           sq [3];
    logic [M_W-1:0]           sum;
    logic [M_W-1:0]           len_sq;
    logic [T_W-1:0]           rem;
    logic                     bad;
    logic [1:0]               slot;
    logic [T_W-1:0]           lane_t_sel [LANES];
    logic                     lane_neg_sel [LANES];
    logic signed [OUT_W-1:0]  rot [LANES];

    assign advance  = !vld_reg[STAGES] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = vld_reg[STAGES];
    assign m_tuser  = bad_reg[STAGES];

    // byte to signed odd value, squares and length
    always_comb
    begin
        byte_in[0] = s_tdata[7:0];
        byte_in[1] = s_tdata[15:8];
        byte_in[2] = s_tdata[23:16];
        tag        = s_tdata[31:24];
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = !byte_in[i][BYTE_W-1];
            mag[i] = neg[i] ? ~byte_in[i] : byte_in[i];
            mag[i] = BYTE_W'({mag[i][BYTE_W-2:0], 1'b1});
            sq[i]  = T_W'(mag[i]) * T_W'(mag[i]);
        end
        sum    = M_W'(sq[0]) + M_W'(sq[1]) + M_W'(sq[2]);
        len_sq = (sum > UNIT_SQ) ? sum : UNIT_SQ;
        rem    = (sum < UNIT_SQ) ? T_W'(UNIT_SQ - sum) : '0;
        bad    = tag < TAG_BASE;
        slot   = bad ? SLOT_W : tag[1:0];
    end

    // slot order: lanes are x, y, z, w
    always_comb
    begin
        case (slot)
            SLOT_X:
            begin
                lane_t_sel   = '{rem, sq[1], sq[2], sq[0]};
                lane_neg_sel = '{1'b0, neg[1], neg[2], neg[0]};
            end
            SLOT_Y:
            begin
                lane_t_sel   = '{sq[1], rem, sq[2], sq[0]};
                lane_neg_sel = '{neg[1], 1'b0, neg[2], neg[0]};
            end
            SLOT_Z:
            begin
                lane_t_sel   = '{sq[1], sq[2], rem, sq[0]};
                lane_neg_sel = '{neg[1], neg[2], 1'b0, neg[0]};
            end
            default:
            begin
                lane_t_sel   = '{sq[0], sq[1], sq[2], rem};
                lane_neg_sel = '{neg[0], neg[1], neg[2], 1'b0};
            end
        endcase
        for (int l = 0; l < LANES; l++)
        begin
            front_next[l].n   = '0;
            front_next[l].p   = $signed({{(ACC_W-M_W){1'b0}}, len_sq});
            front_next[l].q   = -$signed({{(ACC_W-M_W){1'b0}}, len_sq});
            front_next[l].m   = len_sq;
            front_next[l].t   = lane_t_sel[l];
            front_next[l].neg = lane_neg_sel[l];
        end
    end

    // valid chain
    always_comb
    begin
        vld_next = {vld_reg[STAGES-1:0], s_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    // front stage and flag pipeline
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg <= front_next;
            bad_reg   <= {bad_reg[STAGES-1:0], bad};
        end
    end

    // row of cells, most significant bit first
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            sqtq_cell u_cell (
                .clk      (clk),
                .en       (advance),
                .bit_idx  (BIT_W'(STAGES - 1 - s)),
                .lane_in  ((s == 0) ? front_reg[l] : chain[(s == 0) ? 0 : s - 1][l]),
                .lane_out (chain[s][l])
            );
        end
    end

    // sign and pack
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rot[l] = chain[STAGES-1][l].neg ? -$signed(OUT_W'(chain[STAGES-1][l].n))
                                            : $signed(OUT_W'(chain[STAGES-1][l].n));
        end
        m_tdata = {rot[3], rot[2], rot[1], rot[0]};
    end

    `SQTQ_ASSERT_IMP(a_ready_rule, clk, rst_n, 1'b1, s_tready == (!m_tvalid || m_tready))
    `SQTQ_ASSERT_NXT(a_accept_enters, clk, rst_n, s_tvalid && s_tready, vld_reg[0])
    `SQTQ_ASSERT_IMP(a_range_x, clk, rst_n, m_tvalid, rot[0] <= 16'sd16384 && rot[0] >= -16'sd16384)
    `SQTQ_ASSERT_IMP(a_range_w, clk, rst_n, m_tvalid, rot[3] <= 16'sd16384 && rot[3] >= -16'sd16384)

endmodule
